// ===== hw/rtl/rhc_pkg.sv =====
`timescale 1ns / 1ps

package rhc_pkg;

    // Field widths.
    localparam int CHAN_W     = 16;
    localparam int TARGET_W   = 2;
    localparam int HUE_W      = 16;
    localparam int KIND_W     = 2;
    localparam int FRAC_BITS  = 6;
    localparam int Q6_ONE     = 1 << FRAC_BITS;

    // The fractional part of a sector, 60 * n / delta in 1/64 degree, never exceeds 3840,
    // so twelve quotient bits cover it.
    localparam int QUOT_W     = 12;
    localparam int DIVIDEND_W = CHAN_W + QUOT_W;
    localparam int BASE_W     = HUE_W - 1;

    // Hue geometry in degrees.
    localparam int HUE_SECTOR       = 60;
    localparam int HUE_FULL_TURN    = 360;
    localparam int HUE_LIM_RED_LOW  = 60;
    localparam int HUE_LIM_RED_HIGH = 300;
    localparam int HUE_LIM_GRN_HIGH = 180;
    localparam int HUE_LIM_BLU_HIGH = 320;

    localparam logic [DIVIDEND_W-1:0] SECTOR_Q6 = DIVIDEND_W'(HUE_SECTOR * Q6_ONE);

    localparam logic [BASE_W-1:0] BASE_RED   = '0;
    localparam logic [BASE_W-1:0] BASE_GREEN = BASE_W'(2 * HUE_SECTOR * Q6_ONE);
    localparam logic [BASE_W-1:0] BASE_BLUE  = BASE_W'(4 * HUE_SECTOR * Q6_ONE);
    localparam logic [BASE_W-1:0] BASE_WRAP  = BASE_W'(HUE_FULL_TURN * Q6_ONE);

    localparam logic [BASE_W-1:0] LIM_RED_LOW_Q6  = BASE_W'(HUE_LIM_RED_LOW * Q6_ONE);
    localparam logic [BASE_W-1:0] LIM_RED_HIGH_Q6 = BASE_W'(HUE_LIM_RED_HIGH * Q6_ONE);
    localparam logic [BASE_W-1:0] LIM_GRN_HIGH_Q6 = BASE_W'(HUE_LIM_GRN_HIGH * Q6_ONE);
    localparam logic [BASE_W-1:0] LIM_BLU_HIGH_Q6 = BASE_W'(HUE_LIM_BLU_HIGH * Q6_ONE);
    localparam logic [HUE_W-1:0]  HUE_FULL_Q6     = HUE_W'(HUE_FULL_TURN * Q6_ONE);

    // Black reports a hue of minus one degree.
    localparam logic signed [HUE_W-1:0] HUE_BLACK = HUE_W'(-Q6_ONE);

    // Target color codes.
    localparam logic [TARGET_W-1:0] TGT_RED     = 2'd0;
    localparam logic [TARGET_W-1:0] TGT_GREEN   = 2'd1;
    localparam logic [TARGET_W-1:0] TGT_BLUE    = 2'd2;
    localparam logic [TARGET_W-1:0] TGT_UNKNOWN = 2'd3;

    // Hue kind codes.
    localparam logic [KIND_W-1:0] KIND_NORMAL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BLACK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_GRAY   = 2'd2;

    // Default queue depths.
    localparam int MID_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF = 16;

    typedef struct packed {
        logic [CHAN_W-1:0]   red_raw;
        logic [CHAN_W-1:0]   green_raw;
        logic [CHAN_W-1:0]   blue_raw;
        logic [TARGET_W-1:0] target_color;
    } item_t;

    typedef struct packed {
        logic                    is_match;
        logic signed [HUE_W-1:0] hue_q6;
        logic [KIND_W-1:0]       hue_kind;
    } result_t;

    // Classified reading handed from the front to the back.
    typedef struct packed {
        logic [DIVIDEND_W-1:0] dividend;
        logic [CHAN_W-1:0]     delta;
        logic [BASE_W-1:0]     base;
        logic                  neg;
        logic [KIND_W-1:0]     kind;
        logic [TARGET_W-1:0]   target;
    } job_t;

    // One stage of the divider pipeline.
    typedef struct packed {
        logic [DIVIDEND_W-1:0] rem;
        logic [QUOT_W-1:0]     quot;
        logic [CHAN_W-1:0]     delta;
        logic [BASE_W-1:0]     base;
        logic                  neg;
        logic [KIND_W-1:0]     kind;
        logic [TARGET_W-1:0]   target;
    } div_t;

endpackage

// ===== hw/rtl/rhc_fifo.sv =====
`timescale 1ns / 1ps

module rhc_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_wr, do_rd})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hw/rtl/rhc_front.sv =====
`timescale 1ns / 1ps

module rhc_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  rhc_pkg::item_t in_data,
    output logic           in_ready,
    output logic           job_valid,
    output rhc_pkg::job_t  job_data,
    input  logic           job_ready
);

    logic                          valid_reg, valid_next;
    rhc_pkg::job_t                 job_reg;
    rhc_pkg::job_t                 job_d;
    logic                          accept;
    logic                          r_max, g_max;
    logic [rhc_pkg::CHAN_W-1:0]    mx, mn, n;

    assign in_ready  = !valid_reg || job_ready;
    assign accept    = in_valid && in_ready;
    assign job_valid = valid_reg;
    assign job_data  = job_reg;

    // Pick the sector from the largest channel (red wins ties, then green) and fold the
    // signed difference into a magnitude plus a direction.
    always_comb
    begin
        r_max = (in_data.red_raw >= in_data.green_raw) && (in_data.red_raw >= in_data.blue_raw);
        g_max = !r_max && (in_data.green_raw >= in_data.blue_raw);

        mx = r_max ? in_data.red_raw : (g_max ? in_data.green_raw : in_data.blue_raw);
        mn = in_data.red_raw;
        if (in_data.green_raw < mn)
        begin
            mn = in_data.green_raw;
        end
        if (in_data.blue_raw < mn)
        begin
            mn = in_data.blue_raw;
        end

        job_d.delta  = mx - mn;
        job_d.target = in_data.target_color;

        if (r_max)
        begin
            job_d.neg  = in_data.green_raw < in_data.blue_raw;
            n          = job_d.neg ? in_data.blue_raw - in_data.green_raw
                                   : in_data.green_raw - in_data.blue_raw;
            job_d.base = job_d.neg ? rhc_pkg::BASE_WRAP : rhc_pkg::BASE_RED;
        end
        else if (g_max)
        begin
            job_d.neg  = in_data.blue_raw < in_data.red_raw;
            n          = job_d.neg ? in_data.red_raw - in_data.blue_raw
                                   : in_data.blue_raw - in_data.red_raw;
            job_d.base = rhc_pkg::BASE_GREEN;
        end
        else
        begin
            job_d.neg  = in_data.red_raw < in_data.green_raw;
            n          = job_d.neg ? in_data.green_raw - in_data.red_raw
                                   : in_data.red_raw - in_data.green_raw;
            job_d.base = rhc_pkg::BASE_BLUE;
        end

        job_d.dividend = rhc_pkg::DIVIDEND_W'(n) * rhc_pkg::SECTOR_Q6;

        if (mx == '0)
        begin
            job_d.kind = rhc_pkg::KIND_BLACK;
        end
        else if (job_d.delta == '0)
        begin
            job_d.kind = rhc_pkg::KIND_GRAY;
        end
        else
        begin
            job_d.kind = rhc_pkg::KIND_NORMAL;
        end
    end

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (job_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg <= job_d;
        end
    end

endmodule

// ===== hw/rtl/rhc_back.sv =====
`timescale 1ns / 1ps

module rhc_back #(
    parameter int OUT_DEPTH = rhc_pkg::OUT_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  rhc_pkg::job_t     job_data,
    output logic              job_pop,
    output logic              out_valid,
    output rhc_pkg::result_t  out_data,
    input  logic              out_pop
);

    localparam int CW = $clog2(OUT_DEPTH + 1);
    localparam int NS = rhc_pkg::QUOT_W + 1;

    logic [CW-1:0]              occ_reg, occ_next;
    logic                       issue;
    logic                       valid_reg [NS];
    rhc_pkg::div_t              stage_reg [NS];
    rhc_pkg::div_t              stage_next [NS];
    rhc_pkg::div_t              fin;
    logic [rhc_pkg::BASE_W-1:0] h;
    logic                       nz;
    logic [rhc_pkg::BASE_W-1:0] h_floor;
    logic                       hit;

    // Exact comparisons of the hue h + or - a fraction against an integer limit.
    function automatic logic hue_below(input logic [rhc_pkg::BASE_W-1:0] hv,
                                       input logic [rhc_pkg::BASE_W-1:0] lim,
                                       input logic frac_nz, input logic neg);
        hue_below = (hv < lim) || ((hv == lim) && frac_nz && neg);
    endfunction

    function automatic logic hue_above(input logic [rhc_pkg::BASE_W-1:0] hv,
                                       input logic [rhc_pkg::BASE_W-1:0] lim,
                                       input logic frac_nz, input logic neg);
        hue_above = (hv > lim) || ((hv == lim) && frac_nz && !neg);
    endfunction

    // Every issued item holds a slot of the output queue until it is popped.
    assign issue   = job_valid && (occ_reg != CW'(OUT_DEPTH));
    assign job_pop = issue;

    always_comb
    begin
        case ({issue, out_pop})
            2'b10:   occ_next = occ_reg + 1'b1;
            2'b01:   occ_next = occ_reg - 1'b1;
            default: occ_next = occ_reg;
        endcase
    end

    // One restoring divider step per stage, most significant quotient bit first.
    always_comb
    begin
        stage_next[0].rem    = job_data.dividend;
        stage_next[0].quot   = '0;
        stage_next[0].delta  = job_data.delta;
        stage_next[0].base   = job_data.base;
        stage_next[0].neg    = job_data.neg;
        stage_next[0].kind   = job_data.kind;
        stage_next[0].target = job_data.target;
        for (int k = 1; k < NS; k++)
        begin
            stage_next[k] = stage_reg[k-1];
            if (stage_reg[k-1].rem >=
                (rhc_pkg::DIVIDEND_W'(stage_reg[k-1].delta) << (rhc_pkg::QUOT_W - k)))
            begin
                stage_next[k].rem  = stage_reg[k-1].rem -
                    (rhc_pkg::DIVIDEND_W'(stage_reg[k-1].delta) << (rhc_pkg::QUOT_W - k));
                stage_next[k].quot[rhc_pkg::QUOT_W - k] = 1'b1;
            end
        end
    end

    // Window test and hue formatting on the finished quotient.
    always_comb
    begin
        fin     = stage_reg[NS-1];
        nz      = |fin.rem;
        h       = fin.neg ? fin.base - rhc_pkg::BASE_W'(fin.quot)
                          : fin.base + rhc_pkg::BASE_W'(fin.quot);
        h_floor = (fin.neg && nz) ? h - 1'b1 : h;

        case (fin.target)
            rhc_pkg::TGT_RED:
                hit = hue_below(h, rhc_pkg::LIM_RED_LOW_Q6, nz, fin.neg) ||
                      hue_above(h, rhc_pkg::LIM_RED_HIGH_Q6, nz, fin.neg);
            rhc_pkg::TGT_GREEN:
                hit = hue_above(h, rhc_pkg::LIM_RED_LOW_Q6, nz, fin.neg) &&
                      hue_below(h, rhc_pkg::LIM_GRN_HIGH_Q6, nz, fin.neg);
            rhc_pkg::TGT_BLUE:
                hit = hue_above(h, rhc_pkg::LIM_GRN_HIGH_Q6, nz, fin.neg) &&
                      hue_below(h, rhc_pkg::LIM_BLU_HIGH_Q6, nz, fin.neg);
            default:
                hit = 1'b0;
        endcase

        out_data.hue_kind = fin.kind;
        case (fin.kind)
            rhc_pkg::KIND_BLACK:
            begin
                out_data.is_match = (fin.target == rhc_pkg::TGT_RED);
                out_data.hue_q6   = rhc_pkg::HUE_BLACK;
            end
            rhc_pkg::KIND_NORMAL:
            begin
                out_data.is_match = hit;
                out_data.hue_q6   = rhc_pkg::HUE_W'(h_floor);
            end
            default:
            begin
                out_data.is_match = 1'b0;
                out_data.hue_q6   = '0;
            end
        endcase
    end

    assign out_valid = valid_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
            for (int k = 0; k < NS; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            occ_reg      <= occ_next;
            valid_reg[0] <= issue;
            for (int k = 1; k < NS; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NS; k++)
        begin
            stage_reg[k] <= stage_next[k];
        end
    end

endmodule

// ===== hw/rtl/rgb_hue_color_classifier_unit.sv =====
`timescale 1ns / 1ps
// Path: a beat pushed into an idle block passes the front register, the middle queue,
// the 13 divider stages and the output queue before it shows up on the result side.
// Throughput: one beat per cycle sustained while the output queue is drained at that rate;
// the 13-stage divider pipeline sets most of the latency.
// Reset: rst_n clears all queues and valid flags; no beats are pending after reset.

module rgb_hue_color_classifier_unit #(
    parameter int MID_DEPTH = rhc_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = rhc_pkg::OUT_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  rhc_pkg::item_t   item,
    input  logic             pop,
    output logic             empty,
    output rhc_pkg::result_t result
);

    // The front classifies each reading: it finds the largest channel, the sector base,
    // the spread delta and the scaled difference that the back divides by delta.
    // The middle queue lets the front keep accepting while the back waits for space.
    // The back runs a fully pipelined restoring divider and then the exact window test.
    // It only issues a beat when the output queue has a slot reserved for it, so the
    // divider pipeline never has to stall; OUT_DEPTH of at least 15 keeps a full rate.

    logic             front_ready;
    logic             job_valid;
    rhc_pkg::job_t    job_data;
    logic             mid_full;
    logic             mid_empty;
    rhc_pkg::job_t    mid_head;
    logic             mid_pop;
    logic             res_write;
    rhc_pkg::result_t res_data;
    logic             res_full;
    logic             res_pop;

    assign full    = !front_ready;
    assign res_pop = pop && !empty;

    rhc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push),
        .in_data   (item),
        .in_ready  (front_ready),
        .job_valid (job_valid),
        .job_data  (job_data),
        .job_ready (!mid_full)
    );

    rhc_fifo #(
        .WIDTH ($bits(rhc_pkg::job_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_valid),
        .wr_data (job_data),
        .full    (mid_full),
        .rd_en   (mid_pop),
        .rd_data (mid_head),
        .empty   (mid_empty)
    );

    rhc_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!mid_empty),
        .job_data  (mid_head),
        .job_pop   (mid_pop),
        .out_valid (res_write),
        .out_data  (res_data),
        .out_pop   (res_pop)
    );

    rhc_fifo #(
        .WIDTH ($bits(rhc_pkg::result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_write),
        .wr_data (res_data),
        .full    (res_full),
        .rd_en   (res_pop),
        .rd_data (result),
        .empty   (empty)
    );

    // The slot reservation must guarantee that a finished beat always finds room.
    a_no_result_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(res_write && res_full))
        else $error("result written into a full output queue");

    // Black always reports minus one degree.
    a_black_hue: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.hue_kind == rhc_pkg::KIND_BLACK)) |->
        (result.hue_q6 == rhc_pkg::HUE_BLACK))
        else $error("black result with wrong hue");

    // Gray never matches and reports a zero hue.
    a_gray_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.hue_kind == rhc_pkg::KIND_GRAY)) |->
        (!result.is_match && (result.hue_q6 == '0)))
        else $error("gray result matched or has a hue");

    // A normal hue stays within one turn.
    a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.hue_kind == rhc_pkg::KIND_NORMAL)) |->
        (!result.hue_q6[rhc_pkg::HUE_W-1] && (result.hue_q6 < rhc_pkg::HUE_FULL_Q6)))
        else $error("normal hue out of range");

endmodule
